FILE: rtl/core/deck_control_frame_parser_core_defines.svh
// Assertion macros for the deck control frame parser checker.
// No dependencies; included by the files that hold concurrent assertions.
`ifndef DECK_CONTROL_FRAME_PARSER_CORE_DEFINES_SVH
`define DECK_CONTROL_FRAME_PARSER_CORE_DEFINES_SVH

// clocked check, off while reset is asserted
`define DCFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define DCFP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/core/dcfp_pkg.sv
// Shared constants and types for the deck control frame parser.
// No dependencies.
`default_nettype none

package dcfp_pkg;

    localparam int BUF_DEPTH = 17;
    localparam int HDR_BYTES = 2;
    localparam logic [7:0] CNT_MASK = 8'h0f;

    // frame judged on its checksum byte
    typedef struct packed {
        logic       valid;
        logic       ok;
        logic [7:0] cmd;
        logic [7:0] sub;
        logic [3:0] cnt;
    } t_frame_evt;

    typedef struct packed {
        logic [7:0] command_byte;
        logic [7:0] subcommand_byte;
        logic [3:0] data_count;
        logic [3:0] data_index;
        logic [7:0] data_byte;
        logic       has_data;
        logic       checksum_ok;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/dcfp_channels.sv
// Valid/ready channels of the deck control frame parser.
// No dependencies.
`default_nettype none

interface dcfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface dcfp_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] command_byte;
    logic [7:0] subcommand_byte;
    logic [3:0] data_count;
    logic [3:0] data_index;
    logic [7:0] data_byte;
    logic       has_data;
    logic       checksum_ok;
    logic       last;

    modport source (output valid, output command_byte, output subcommand_byte,
                    output data_count, output data_index, output data_byte,
                    output has_data, output checksum_ok, output last, input ready);
    modport sink (input valid, input command_byte, input subcommand_byte,
                  input data_count, input data_index, input data_byte,
                  input has_data, input checksum_ok, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dcfp_assembler.sv
// Frame assembler: byte counter, running checksum and frame buffer.
// Depends on dcfp_pkg.
`default_nettype none

module dcfp_assembler (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_take,
    input  wire logic [7:0]            i_byte,
    input  wire logic [3:0]            i_rd_idx,
    output      logic                  o_chk_pos,
    output      dcfp_pkg::t_frame_evt  o_evt,
    output      logic [7:0]            o_rd_data
);

    logic [4:0] r_count, n_count;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_buf [dcfp_pkg::BUF_DEPTH];

    logic [3:0] cnt;
    logic [4:0] rd_addr;

    assign cnt = r_buf[0][3:0] & dcfp_pkg::CNT_MASK[3:0];

    assign o_chk_pos = (r_count >= 5'(dcfp_pkg::HDR_BYTES)) &&
                       ((r_count >= ({1'b0, cnt} + 5'(dcfp_pkg::HDR_BYTES))) ||
                        (r_count >= 5'(dcfp_pkg::BUF_DEPTH)));

    always_comb begin
        o_evt.valid = i_take && o_chk_pos;
        o_evt.ok    = (i_byte == r_sum);
        o_evt.cmd   = r_buf[0];
        o_evt.sub   = r_buf[1];
        o_evt.cnt   = cnt;
    end

    // data byte i sits after the two header bytes
    assign rd_addr = {1'b0, i_rd_idx} + 5'(dcfp_pkg::HDR_BYTES);

    always_comb begin
        if (rd_addr < 5'(dcfp_pkg::BUF_DEPTH)) begin
            o_rd_data = r_buf[rd_addr];
        end else begin
            o_rd_data = '0;
        end
    end

    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        if (i_take) begin
            if (o_chk_pos) begin
                n_count = '0;
                n_sum   = '0;
            end else begin
                n_count = r_count + 5'd1;
                n_sum   = r_sum + i_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && !o_chk_pos) begin
            r_buf[r_count] <= i_byte;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/deck_control_frame_parser_core.sv
// A frame's first request is valid in the cycle after its checksum byte is taken.
// Rx takes one byte per cycle when not busy; a good frame with N > 0 data bytes yields N
// requests, one per cycle if the result side is ready, with rx ready low while they issue.
// A checksum byte also waits for the result register to be free.
// Reset (synchronous, active low) clears the counter, checksum and output valid;
// the frame buffer holds no reset and is read only after being written.
`default_nettype none

module deck_control_frame_parser_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dcfp_rx_if.sink   i_rx,
    dcfp_res_if.source o_res
);

    logic                 chk_pos;
    logic                 take;
    logic                 out_free;
    logic [3:0]           rd_idx;
    logic [7:0]           rd_data;
    dcfp_pkg::t_frame_evt evt;

    logic                 r_ov, n_ov;
    dcfp_pkg::t_result    r_out, n_out;
    logic                 r_busy, n_busy;
    logic [3:0]           r_idx, n_idx;
    logic [7:0]           r_cmd, n_cmd;
    logic [7:0]           r_sub, n_sub;
    logic [3:0]           r_cnt, n_cnt;

    assign out_free   = !r_ov || o_res.ready;
    assign i_rx.ready = !r_busy && (!chk_pos || out_free);
    assign take       = i_rx.valid && i_rx.ready;
    assign rd_idx     = r_busy ? r_idx : 4'd0;

    dcfp_assembler u_asm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_byte    (i_rx.rx_byte),
        .i_rd_idx  (rd_idx),
        .o_chk_pos (chk_pos),
        .o_evt     (evt),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_ov   = r_ov;
        n_out  = r_out;
        n_busy = r_busy;
        n_idx  = r_idx;
        n_cmd  = r_cmd;
        n_sub  = r_sub;
        n_cnt  = r_cnt;
        if (r_ov && o_res.ready) begin
            n_ov = 1'b0;
        end
        if (evt.valid) begin
            n_ov                  = 1'b1;
            n_out.command_byte    = evt.cmd;
            n_out.subcommand_byte = evt.sub;
            n_out.data_count      = evt.cnt;
            n_out.data_index      = 4'd0;
            n_out.checksum_ok     = evt.ok;
            n_out.has_data        = evt.ok && (evt.cnt != 4'd0);
            n_out.data_byte       = n_out.has_data ? rd_data : 8'd0;
            n_out.last            = !(evt.ok && (evt.cnt > 4'd1));
            n_busy                = evt.ok && (evt.cnt > 4'd1);
            n_idx                 = 4'd1;
            n_cmd                 = evt.cmd;
            n_sub                 = evt.sub;
            n_cnt                 = evt.cnt;
        end else if (r_busy && out_free) begin
            n_ov                  = 1'b1;
            n_out.command_byte    = r_cmd;
            n_out.subcommand_byte = r_sub;
            n_out.data_count      = r_cnt;
            n_out.data_index      = r_idx;
            n_out.data_byte       = rd_data;
            n_out.has_data        = 1'b1;
            n_out.checksum_ok     = 1'b1;
            n_out.last            = (r_idx == r_cnt - 4'd1);
            n_idx                 = r_idx + 4'd1;
            if (n_out.last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_ov   <= n_ov;
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_cmd <= n_cmd;
        r_sub <= n_sub;
        r_cnt <= n_cnt;
    end

    assign o_res.valid           = r_ov;
    assign o_res.command_byte    = r_out.command_byte;
    assign o_res.subcommand_byte = r_out.subcommand_byte;
    assign o_res.data_count      = r_out.data_count;
    assign o_res.data_index      = r_out.data_index;
    assign o_res.data_byte       = r_out.data_byte;
    assign o_res.has_data        = r_out.has_data;
    assign o_res.checksum_ok     = r_out.checksum_ok;
    assign o_res.last            = r_out.last;

endmodule

`default_nettype wire

FILE: rtl/core/dcfp_checker.sv
// Port-level checks for deck_control_frame_parser_core, attached by bind.
// Depends on deck_control_frame_parser_core_defines.svh and the top level.
`default_nettype none
`include "deck_control_frame_parser_core_defines.svh"

module dcfp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       i_ready,
    input wire logic [3:0] i_data_count,
    input wire logic [3:0] i_data_index,
    input wire logic [7:0] i_data_byte,
    input wire logic       i_has_data,
    input wire logic       i_checksum_ok,
    input wire logic       i_last
);

    `DCFP_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !i_valid, "result valid after reset")
    `DCFP_ASSERT(a_hold, (i_valid && !i_ready) |=> (i_valid && $stable(i_data_byte) && $stable(i_data_index) && $stable(i_last)), "stalled request changed")
    `DCFP_ASSERT(a_single, (i_valid && !i_has_data) |-> (i_last && i_data_byte == 8'd0 && i_data_index == 4'd0), "bad single request")
    `DCFP_ASSERT(a_data, (i_valid && i_has_data) |-> (i_checksum_ok && i_data_index < i_data_count && (i_last == (i_data_index == i_data_count - 4'd1))), "data request out of order")

endmodule

bind deck_control_frame_parser_core dcfp_checker u_dcfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_res.valid),
    .i_ready       (o_res.ready),
    .i_data_count  (o_res.data_count),
    .i_data_index  (o_res.data_index),
    .i_data_byte   (o_res.data_byte),
    .i_has_data    (o_res.has_data),
    .i_checksum_ok (o_res.checksum_ok),
    .i_last        (o_res.last)
);

`default_nettype wire

FILE: tb/deck_control_frame_parser_core_checker.sv
// Watcher for the deck control frame parser: tracks frames from the rx channel,
// builds the expected requests and compares them with the result channel.
// Depends on dcfp_pkg and the channel interfaces in dcfp_channels.sv.
`default_nettype none

module deck_control_frame_parser_core_checker
    import dcfp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dcfp_rx_if        i_rx,
    dcfp_res_if       i_res,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [4:0] frame_len = '0;
    logic [7:0] frame_sum = '0;
    logic [7:0] frame_bytes [BUF_DEPTH];
    t_result    expected_results [$];
    int         fail_count = 0;
    int         pending = 0;
    int         checked = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_checked    = checked;

    initial begin
        foreach (frame_bytes[i]) frame_bytes[i] = '0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        logic [7:0] cnt_byte;
        logic [3:0] cnt;
        t_result    r;
        cnt_byte = frame_bytes[0] & CNT_MASK;
        cnt = cnt_byte[3:0];
        if (frame_len < HDR_BYTES
                || (frame_len < cnt + HDR_BYTES && frame_len < BUF_DEPTH)) begin
            frame_bytes[frame_len] = b;
            frame_sum = frame_sum + b;
            frame_len = frame_len + 1'b1;
        end else begin
            r.command_byte    = frame_bytes[0];
            r.subcommand_byte = frame_bytes[1];
            r.data_count      = cnt;
            r.data_index      = '0;
            r.data_byte       = '0;
            r.has_data        = 1'b0;
            r.checksum_ok     = (b == frame_sum);
            r.last            = 1'b1;
            if (b != frame_sum || cnt == 0) begin
                expected_results.push_back(r);
            end else begin
                for (int i = 0; i < cnt; i++) begin
                    r.data_index = i[3:0];
                    r.data_byte  = frame_bytes[i + HDR_BYTES];
                    r.has_data   = 1'b1;
                    r.last       = (i == cnt - 1);
                    expected_results.push_back(r);
                end
            end
            frame_len = '0;
            frame_sum = '0;
        end
    endtask

    task automatic compare_request();
        t_result got;
        t_result want;
        got.command_byte    = i_res.command_byte;
        got.subcommand_byte = i_res.subcommand_byte;
        got.data_count      = i_res.data_count;
        got.data_index      = i_res.data_index;
        got.data_byte       = i_res.data_byte;
        got.has_data        = i_res.has_data;
        got.checksum_ok     = i_res.checksum_ok;
        got.last            = i_res.last;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected request cmd=%h sub=%h idx=%h",
                got.command_byte, got.subcommand_byte, got.data_index));
        end else begin
            want = expected_results.pop_front();
            checked++;
            if (got.command_byte !== want.command_byte
                    || got.subcommand_byte !== want.subcommand_byte
                    || got.data_count !== want.data_count
                    || got.data_index !== want.data_index
                    || got.data_byte !== want.data_byte
                    || got.has_data !== want.has_data
                    || got.checksum_ok !== want.checksum_ok
                    || got.last !== want.last) begin
                report_mismatch($sformatf(
                    "got cmd=%h sub=%h cnt=%h idx=%h data=%h has=%b ok=%b last=%b, want cmd=%h sub=%h cnt=%h idx=%h data=%h has=%b ok=%b last=%b",
                    got.command_byte, got.subcommand_byte, got.data_count, got.data_index,
                    got.data_byte, got.has_data, got.checksum_ok, got.last,
                    want.command_byte, want.subcommand_byte, want.data_count,
                    want.data_index, want.data_byte, want.has_data, want.checksum_ok,
                    want.last));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_len = '0;
            frame_sum = '0;
            expected_results.delete();
        end else begin
            if (i_rx.valid && i_rx.ready) absorb_byte(i_rx.rx_byte);
            if (i_res.valid && i_res.ready) compare_request();
        end
        pending = expected_results.size();
    end

endmodule

`default_nettype wire

FILE: tb/deck_control_frame_parser_core_tb.sv
// Top of the deck control frame parser bench: clock, reset, byte stimulus and
// result-side backpressure. Depends on dcfp_pkg, dcfp_channels.sv, the core and
// deck_control_frame_parser_core_checker.
`default_nettype none

module deck_control_frame_parser_core_tb;
    import dcfp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam real CLK_PERIOD     = 12.0;
    localparam int  RANDOM_ITEMS   = 300;
    localparam int  TIMEOUT_CYCLES = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dcfp_rx_if  rx_ch ();
    dcfp_res_if res_ch ();

    int fail_count;
    int pending;
    int checked;

    logic [7:0] payload [16];
    logic [4:0] tb_len = '0;
    logic [3:0] tb_cnt = '0;
    int         bytes_sent = 0;
    int         frames_sent = 0;
    int         frames_bad = 0;
    bit         gap_on = 1'b1;
    bit         hold_req = 1'b0;

    deck_control_frame_parser_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    deck_control_frame_parser_core_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (rx_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout: %0d requests still outstanding", pending);
        $display("TEST FAILED");
        $finish;
    end

    // result side: random ready, plus one long hold on request
    initial begin
        int stall_left;
        int burst_left;
        int r;
        stall_left = 0;
        burst_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                stall_left = 80;
                res_ch.ready <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                res_ch.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    burst_left = $urandom_range(5, 30);
                    res_ch.ready <= 1'b1;
                end else if (r < 60) begin
                    stall_left = $urandom_range(1, 3);
                    res_ch.ready <= 1'b0;
                end else if (r < 64) begin
                    stall_left = $urandom_range(10, 40);
                    res_ch.ready <= 1'b0;
                end else begin
                    res_ch.ready <= 1'b1;
                end
            end
        end
    end

    task automatic idle_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 60) n = 0;
        else if (r < 92) n = $urandom_range(1, 3);
        else n = $urandom_range(8, 30);
        if (n > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        bytes_sent++;
        // keep track of frame alignment so new frames start on a boundary
        if (tb_len < HDR_BYTES || tb_len < tb_cnt + HDR_BYTES) begin
            if (tb_len == 0) tb_cnt = b[3:0];
            tb_len++;
        end else begin
            tb_len = '0;
        end
        if (gap_on) idle_gap();
    endtask

    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] sub,
                              input bit corrupt);
        logic [7:0] sum;
        while (tb_len != 0) send_byte(8'($urandom_range(0, 255)));
        sum = cmd + sub;
        send_byte(cmd);
        send_byte(sub);
        for (int i = 0; i < cmd[3:0]; i++) begin
            send_byte(payload[i]);
            sum = sum + payload[i];
        end
        if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(sum);
        frames_sent++;
        if (corrupt) frames_bad++;
    endtask

    task automatic random_frame();
        int r;
        logic [3:0] cnt;
        r = $urandom_range(0, 99);
        if (r < 70) cnt = 4'($urandom_range(0, 3));
        else if (r < 90) cnt = 4'($urandom_range(4, 8));
        else if (r < 95) cnt = 4'($urandom_range(9, 14));
        else cnt = 4'hf;
        foreach (payload[i]) payload[i] = 8'($urandom_range(0, 255));
        send_frame({4'($urandom_range(0, 15)), cnt}, 8'($urandom_range(0, 255)),
                   $urandom_range(0, 99) < 15);
    endtask

    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int directed;
        bit hold_done;
        bit drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        i_rst_n       <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty frame of zeros, bad checksum on an empty frame,
        // then a frame with 15 data bytes, an all-ones command byte and a wrapping sum
        foreach (payload[i]) payload[i] = 8'h00;
        send_frame(8'h00, 8'h00, 1'b0);
        send_frame(8'hf0, 8'hff, 1'b1);
        foreach (payload[i]) payload[i] = i[0] ? 8'hff : 8'h00;
        send_frame(8'hff, 8'ha5, 1'b0);
        directed = bytes_sent;

        while (bytes_sent < directed + RANDOM_ITEMS) begin
            if (!hold_done && bytes_sent > directed + 100) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
                gap_on    = 1'b0;
                repeat (4) random_frame();
            end
            if (!drain_done && bytes_sent > directed + 200) begin
                drain_done = 1'b1;
                wait_drained();
            end
            gap_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 10) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                random_frame();
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Ran %0d bytes: %0d framed (%0d with a bad checksum) plus noise bytes,",
                 bytes_sent, frames_sent, frames_bad);
        $display("%0d requests checked under random and long result-side stalls.", checked);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
